### rtl/zcd_pkg.sv
// Shared types, op codes, key constants and the CRC-32 byte step for the zip decrypt unit.
package zcd_pkg;

  localparam logic [1:0] OP_RESTART  = 2'd0;
  localparam logic [1:0] OP_PASSWORD = 2'd1;
  localparam logic [1:0] OP_DECRYPT  = 2'd2;

  localparam logic [31:0] KEY_ZERO_INIT = 32'h1234_5678;
  localparam logic [31:0] KEY_ONE_INIT  = 32'h2345_6789;
  localparam logic [31:0] KEY_TWO_INIT  = 32'h3456_7890;
  localparam logic [31:0] LCG_MULT      = 32'd134775813;
  localparam logic [31:0] CRC_POLY      = 32'hEDB8_8320;

  // Commands from the controller to the datapath, one bit per step.
  typedef struct packed {
    logic load_byte;   // capture data_byte on a transfer
    logic restart;     // load the starting keys
    logic ks_en;       // form keystream byte from key_two
    logic mix_en;      // key_zero CRC step and key_one add
    logic mix_dec;     // mix with ciphertext ^ keystream, load output byte
    logic mult_en;     // key_one linear congruential step
    logic crc2_en;     // key_two CRC step with top byte of key_one
  } dp_cmd_t;

  // Reflected CRC-32 over one byte, bit at a time.
  function automatic logic [31:0] crc_byte_step(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] r;
    r = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

endpackage

### rtl/zip_traditional_stream_decrypt_unit.sv
// Top level of the traditional zip cipher byte-stream decryptor.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_ready   in_op[1:0], in_data_byte[7:0]
//   out      output     out_valid / out_ready out_plain_byte[7:0]
//
// Restart items finish in idle; password items pass mix, mult and crc2;
// decrypt items pass ks, mix, mult and crc2: the 16x16 keystream multiply,
// key_zero CRC and key_one add, 32x32 key_one multiply, key_two CRC step.
// Synchronous active-low reset loads the starting keys and empties the output.
// The output register holds a byte until its transfer; a decrypt item stalls
// in its mix cycle only while an earlier byte still waits there.
module zip_traditional_stream_decrypt_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_op,
  input  logic [7:0] in_data_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_plain_byte
);
  import zcd_pkg::*;

  dp_cmd_t cmd;

  zcd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_op),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  zcd_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_data_byte   (in_data_byte),
    .out_plain_byte (out_plain_byte)
  );

endmodule

### rtl/zcd_dpath.sv
// Key registers, keystream multiply, key update steps and output byte register.
module zcd_dpath (
  input  logic             clk,
  input  logic             rst_n,
  input  zcd_pkg::dp_cmd_t cmd,
  input  logic [7:0]       in_data_byte,
  output logic [7:0]       out_plain_byte
);
  import zcd_pkg::*;

  logic [31:0] key_zero_r, key_zero_nxt;
  logic [31:0] key_one_r, key_one_nxt;
  logic [31:0] key_two_r, key_two_nxt;
  logic [7:0]  byte_r;
  logic [7:0]  ks_r;
  logic [7:0]  plain_r;
  logic [15:0] ks_t;
  logic [31:0] ks_prod;
  logic [7:0]  mix_byte;

  // t has bit 1 forced high; t ^ 1 flips bit 0
  assign ks_t     = {key_two_r[15:2], 1'b1, key_two_r[0]};
  assign ks_prod  = {16'd0, ks_t} * {16'd0, ks_t ^ 16'd1};
  assign mix_byte = cmd.mix_dec ? (byte_r ^ ks_r) : byte_r;

  always_comb begin
    key_zero_nxt = key_zero_r;
    key_one_nxt  = key_one_r;
    key_two_nxt  = key_two_r;
    if (cmd.restart) begin
      key_zero_nxt = KEY_ZERO_INIT;
      key_one_nxt  = KEY_ONE_INIT;
      key_two_nxt  = KEY_TWO_INIT;
    end else if (cmd.mix_en) begin
      key_zero_nxt = crc_byte_step(key_zero_r, mix_byte);
      key_one_nxt  = key_one_r + {24'd0, key_zero_nxt[7:0]};
    end else if (cmd.mult_en) begin
      key_one_nxt  = key_one_r * LCG_MULT + 32'd1;
    end else if (cmd.crc2_en) begin
      key_two_nxt  = crc_byte_step(key_two_r, key_one_r[31:24]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_zero_r <= KEY_ZERO_INIT;
      key_one_r  <= KEY_ONE_INIT;
      key_two_r  <= KEY_TWO_INIT;
    end else begin
      key_zero_r <= key_zero_nxt;
      key_one_r  <= key_one_nxt;
      key_two_r  <= key_two_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_byte) byte_r <= in_data_byte;
    if (cmd.ks_en) ks_r <= ks_prod[15:8];
    if (cmd.mix_en && cmd.mix_dec) plain_r <= mix_byte;
  end

  assign out_plain_byte = plain_r;

endmodule

### rtl/zcd_ctrl.sv
// Sequencer for restart, password and decrypt items, plus output valid tracking.
module zcd_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [1:0]       in_op,
  output logic             in_ready,
  input  logic             out_ready,
  output logic             out_valid,
  output zcd_pkg::dp_cmd_t cmd
);
  import zcd_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_KS   = 5'b00010,
    ST_MIX  = 5'b00100,
    ST_MULT = 5'b01000,
    ST_CRC2 = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   dec_r, dec_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_xfer;
  logic   mix_go;

  assign in_ready = (state_r == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;
  // a decrypt byte waits in mix until the output register is free
  assign mix_go   = !dec_r || !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    dec_nxt       = dec_r;
    cmd           = '0;
    cmd.load_byte = in_xfer;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          case (in_op)
            OP_RESTART:  cmd.restart = 1'b1;
            OP_PASSWORD: begin
              dec_nxt   = 1'b0;
              state_nxt = ST_MIX;
            end
            OP_DECRYPT: begin
              dec_nxt   = 1'b1;
              state_nxt = ST_KS;
            end
            default: ;
          endcase
        end
      end
      ST_KS: begin
        cmd.ks_en = 1'b1;
        state_nxt = ST_MIX;
      end
      ST_MIX: begin
        cmd.mix_dec = dec_r;
        if (mix_go) begin
          cmd.mix_en = 1'b1;
          state_nxt  = ST_MULT;
        end
      end
      ST_MULT: begin
        cmd.mult_en = 1'b1;
        state_nxt   = ST_CRC2;
      end
      ST_CRC2: begin
        cmd.crc2_en = 1'b1;
        state_nxt   = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.mix_en && cmd.mix_dec) out_valid_nxt = 1'b1;
    else if (out_ready)            out_valid_nxt = 1'b0;
    else                           out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      dec_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dec_r       <= dec_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

### dv/zip_traditional_stream_decrypt_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the zip traditional stream decrypt unit.
module zip_traditional_stream_decrypt_unit_tb;
  import zcd_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int MAX_GAP       = 11;
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_CYCLES   = 300;
  localparam int RANDOM_ITEMS  = 700;

  logic       clk          = 1'b0;
  logic       rst_n        = 1'b0;
  logic       in_valid     = 1'b0;
  logic       in_ready;
  logic [1:0] in_op        = OP_RESTART;
  logic [7:0] in_data_byte = 8'h00;
  logic       out_valid;
  logic       out_ready    = 1'b0;
  logic [7:0] out_plain_byte;

  // Predicted cipher keys and the plain bytes still owed by the block.
  logic [31:0] key_a = KEY_ZERO_INIT;
  logic [31:0] key_b = KEY_ONE_INIT;
  logic [31:0] key_c = KEY_TWO_INIT;
  logic [7:0]  plain_expected[$];

  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  int rx_hold_cycles = 0;
  int fail_count = 0;
  int items_sent = 0;
  int bytes_checked = 0;
  int password_count = 0;
  int restart_count = 0;
  int unused_count = 0;

  zip_traditional_stream_decrypt_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_data_byte   (in_data_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_plain_byte (out_plain_byte)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    repeat (8) c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    return c;
  endfunction

  function automatic logic [7:0] keystream(input logic [31:0] k2);
    logic [15:0] t;
    logic [31:0] prod;
    t = k2[15:0] | 16'h0002;
    prod = {16'h0, t} * {16'h0, t ^ 16'h0001};
    return prod[15:8];
  endfunction

  task automatic absorb_byte(input logic [7:0] b);
    key_a = crc32_byte(key_a, b);
    key_b = (key_b + {24'h0, key_a[7:0]}) * LCG_MULT + 32'd1;
    key_c = crc32_byte(key_c, key_b[31:24]);
  endtask

  task automatic predict_item(input logic [1:0] op, input logic [7:0] b);
    logic [7:0] plain;
    case (op)
      OP_RESTART: begin
        key_a = KEY_ZERO_INIT;
        key_b = KEY_ONE_INIT;
        key_c = KEY_TWO_INIT;
        restart_count++;
      end
      OP_PASSWORD: begin
        absorb_byte(b);
        password_count++;
      end
      OP_DECRYPT: begin
        plain = b ^ keystream(key_c);
        absorb_byte(plain);
        plain_expected.insert(plain_expected.size(), plain);
      end
      default: begin
        unused_count++;
      end
    endcase
  endtask

  // Call at a rising edge; returns at the edge of the transfer with valid still high.
  task automatic send_item(input logic [1:0] op, input logic [7:0] b);
    int gap;
    gap = tx_idle ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_op        <= op;
    in_data_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_item(op, b);
    items_sent++;
  endtask

  // Drop valid, then hold until every plain byte has come back.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (plain_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic check_plain(input logic [7:0] got);
    logic [7:0] exp;
    if (plain_expected.size() == 0) begin
      $error("plain_byte: no result expected, actual %02h", got);
      fail_count++;
    end else begin
      exp = plain_expected.pop_front();
      if (got !== exp) begin
        $error("plain_byte expected %02h actual %02h", exp, got);
        fail_count++;
      end
      bytes_checked++;
    end
  endtask

  task automatic test_directed();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    send_item(OP_DECRYPT, 8'h00);
    send_item(OP_DECRYPT, 8'hFF);
    send_item(OP_RESTART, 8'hFF);
    send_item(OP_DECRYPT, 8'h00);
    send_item(OP_PASSWORD, 8'h00);
    send_item(OP_PASSWORD, 8'hFF);
    send_item(OP_PASSWORD, 8'hA5);
    send_item(OP_DECRYPT, 8'h5A);
    // unused op must leave the keys alone
    send_item(OP_UNUSED, 8'hFF);
    send_item(OP_DECRYPT, 8'hFF);
    send_item(OP_UNUSED, 8'h00);
    send_item(OP_DECRYPT, 8'h00);
    send_item(OP_RESTART, 8'h00);
    send_item(OP_PASSWORD, 8'h80);
    send_item(OP_PASSWORD, 8'h01);
    send_item(OP_DECRYPT, 8'h80);
    send_item(OP_DECRYPT, 8'h01);
    send_item(OP_RESTART, 8'h5A);
    send_item(OP_DECRYPT, 8'hC3);
    wait_idle();
  endtask

  // Restart, a password, then a ciphertext run; some runs get stray items mixed in.
  task automatic test_password_streams();
    int target;
    int pw_len;
    int data_len;
    bit noisy;
    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      noisy = ($urandom_range(0, 4) == 0);
      pw_len = $urandom_range(0, 12);
      data_len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
      send_item(OP_RESTART, 8'($urandom));
      repeat (pw_len) begin
        send_item(OP_PASSWORD, 8'($urandom));
        if (noisy && $urandom_range(0, 3) == 0)
          send_item(2'($urandom_range(0, 3)), 8'($urandom));
      end
      repeat (data_len) begin
        send_item(OP_DECRYPT, 8'($urandom));
        if (noisy && $urandom_range(0, 3) == 0)
          send_item(2'($urandom_range(0, 3)), 8'($urandom));
      end
    end
    wait_idle();
  endtask

  // Stall the result side long enough that the block stops taking input.
  task automatic test_backpressure();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    rx_hold_cycles = HOLD_CYCLES;
    send_item(OP_RESTART, 8'h00);
    send_item(OP_PASSWORD, 8'($urandom));
    send_item(OP_PASSWORD, 8'($urandom));
    repeat (40) send_item(OP_DECRYPT, 8'($urandom));
    wait_idle();
  endtask

  task automatic test_back_to_back();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    send_item(OP_RESTART, 8'($urandom));
    repeat (4) send_item(OP_PASSWORD, 8'($urandom));
    repeat (60) send_item(OP_DECRYPT, 8'($urandom));
    wait_idle();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_password_streams();
    test_backpressure();
    test_back_to_back();
    $display("Covered %0d transfers: %0d plain bytes checked, %0d password bytes, %0d restarts,",
             items_sent, bytes_checked, password_count, restart_count);
    $display("%0d unused-op items, random idling on both sides and a long output stall.",
             unused_count);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    int hold;
    int gap;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (rx_hold_cycles > 0) begin
        hold = rx_hold_cycles;
        rx_hold_cycles = 0;
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end else begin
        gap = rx_idle ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      check_plain(out_plain_byte);
    end
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

### sim.f
rtl/zcd_pkg.sv
rtl/zcd_dpath.sv
rtl/zcd_ctrl.sv
rtl/zip_traditional_stream_decrypt_unit.sv
dv/zip_traditional_stream_decrypt_unit_tb.sv
